// ===== design/e2c_pkg.sv =====
`default_nettype none

package e2c_pkg;

  // Field widths
  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned OFFSET_W  = 18;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned OUT_DATA_W = 48;

  // Time constants
  localparam logic [5:0] MINUTE_LEN = 6'd60;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 18'sd86400;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = -18'sd86400;

  // Bias of whole days (a multiple of seven) that keeps the dividend positive
  localparam logic [15:0] BIAS_DAYS = 16'd25004;
  localparam logic signed [33:0] BIAS_SECS = 34'sd2160345600;

  // Reciprocals for the constant divisions; a day is 675 * 2^7 seconds.
  // Each is the ceiling of 2^k over the divisor, exact over its input range.
  localparam logic [9:0]  DAY_ODD     = 10'd675;
  localparam logic [26:0] DAY_RECIP   = 27'd101806633;  // 2^36 / 675
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;      // 2^19 / 7
  localparam logic [15:0] WEEK_LEN    = 16'd7;
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;       // 2^21 / 225, after >> 4
  localparam logic [15:0] MINUTE_RECIP = 16'd34953;     // 2^19 / 15, after >> 2

  localparam logic [7:0] BASE_YEARS = 8'd70;   // 1970 minus 1900
  localparam logic [7:0] YEARS_2100 = 8'd200;
  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] FEB = 4'd1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_DAYS,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_MON
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MON,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic mon_done;
  } status_t;

  // Leap rule over years since 1900; 2000 is leap, 1900 and 2100 are not
  function automatic logic is_leap(input logic [7:0] ys);
    return (ys[1:0] == 2'b00) && (ys != 8'd0) && (ys != YEARS_2100);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] ys);
    return is_leap(ys) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      FEB:                       len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/e2c_ctrl.sv =====
`default_nettype none

module e2c_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output e2c_pkg::cmd_t         cmd_o,
  input  wire e2c_pkg::status_t sts_i
);
  import e2c_pkg::*;

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence the conversion phases
  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.op        = OP_NONE;
    cmd_o.out_load  = 1'b0;
    in_ready_o      = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        state_d  = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.op = OP_DAYS;
        state_d  = ST_HOUR;
      end
      ST_HOUR: begin
        cmd_o.op = OP_HOUR;
        state_d  = ST_MIN;
      end
      ST_MIN: begin
        cmd_o.op = OP_MIN;
        state_d  = ST_YEAR;
      end
      ST_YEAR: begin
        cmd_o.op = OP_YEAR;
        if (sts_i.year_done) begin
          state_d = ST_MON;
        end
      end
      ST_MON: begin
        cmd_o.op = OP_MON;
        if (sts_i.mon_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/e2c_datapath.sv =====
`default_nettype none

module e2c_datapath (
  input  wire logic                                  clk_i,
  input  wire e2c_pkg::cmd_t                         cmd_i,
  input  wire logic signed [e2c_pkg::EPOCH_W-1:0]    epoch_seconds_i,
  input  wire logic signed [e2c_pkg::OFFSET_W-1:0]   offset_seconds_i,
  output e2c_pkg::status_t                           sts_o,
  output logic [e2c_pkg::OUT_DATA_W-1:0]             result_o
);
  import e2c_pkg::*;

  logic [32:0]        u_q;      // biased seconds
  logic [15:0]        q_q;      // biased day number
  logic [16:0]        r_q;      // seconds of the day
  logic [10:0]        day_min_q; // minutes of the day
  logic [2:0]         w_q;      // biased day number mod 7
  logic [4:0]         hour_q;
  logic [5:0]         min_q;
  logic [5:0]         sec_q;
  logic signed [15:0] days_q;
  logic [7:0]         ys_q;
  logic [8:0]         yday_q;
  logic [3:0]         mon_q;
  logic [OUT_DATA_W-1:0] result_q;

  logic signed [OFFSET_W-1:0] off_sat;
  logic signed [33:0] total;
  logic signed [33:0] biased;
  logic [52:0]        day_prod;
  logic [25:0]        day_rem;
  logic [32:0]        week_prod;
  logic [15:0]        week_rem;
  logic [26:0]        hour_prod;
  logic [30:0]        min_prod;
  logic [10:0]        min_full;
  logic [16:0]        sec_full;
  logic [16:0]        days_full;
  logic [8:0]         ylen_cur;
  logic [8:0]         ylen_prev;
  logic               year_fwd;
  logic               year_back;
  logic [4:0]         mlen;
  logic               mon_adv;
  logic [2:0]         wd_sum;
  logic [2:0]         weekday;

  // Clamp the offset and bias the sum so the division sees a positive value
  always_comb begin
    if (offset_seconds_i > OFFSET_MAX) begin
      off_sat = OFFSET_MAX;
    end else if (offset_seconds_i < OFFSET_MIN) begin
      off_sat = OFFSET_MIN;
    end else begin
      off_sat = offset_seconds_i;
    end
    total  = 34'(epoch_seconds_i) + 34'(off_sat);
    biased = total + BIAS_SECS;
  end

  // Day number: drop the 2^7 factor, then multiply by the reciprocal of 675
  assign day_prod = {27'd0, u_q[32:7]} * {26'd0, DAY_RECIP};
  assign day_rem  = u_q[32:7] - ({10'd0, q_q} * {16'd0, DAY_ODD});

  // Day number mod 7 for the weekday
  assign week_prod = {17'd0, q_q} * {16'd0, WEEK_RECIP};
  assign week_rem  = q_q - ({2'd0, week_prod[32:19]} * WEEK_LEN);

  // Hours and minutes of the day, then the leftovers within hour and minute
  assign hour_prod = {14'd0, r_q[16:4]} * {13'd0, HOUR_RECIP};
  assign min_prod  = {16'd0, r_q[16:2]} * {15'd0, MINUTE_RECIP};
  assign min_full  = day_min_q - ({6'd0, hour_q} * {5'd0, MINUTE_LEN});
  assign sec_full  = r_q - ({6'd0, day_min_q} * {11'd0, MINUTE_LEN});

  // Unbias the day number
  assign days_full = {1'b0, q_q} - {1'b0, BIAS_DAYS};

  // Year stepping, forward while a whole year fits, backward while negative
  assign ylen_cur  = year_len(ys_q);
  assign ylen_prev = year_len(ys_q - 8'd1);
  assign year_fwd  = !days_q[15] && (days_q >= $signed({7'd0, ylen_cur}));
  assign year_back = days_q[15];

  // Month stepping through the month-length table of the found year
  assign mlen    = month_len(is_leap(ys_q), mon_q);
  assign mon_adv = (mon_q < LAST_MONTH) && (days_q[8:0] >= {4'd0, mlen});

  assign sts_o.year_done = !year_fwd && !year_back;
  assign sts_o.mon_done  = !mon_adv;

  // Weekday: 1970-01-01 was a Thursday
  assign wd_sum  = w_q + 3'd4;
  assign weekday = (w_q >= 3'd3) ? (w_q - 3'd3) : wd_sum;

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        u_q <= biased[32:0];
      end
      OP_DIV: begin
        q_q <= day_prod[51:36];
      end
      OP_DAYS: begin
        r_q    <= {day_rem[9:0], u_q[6:0]};
        w_q    <= week_rem[2:0];
        days_q <= $signed(days_full[15:0]);
        ys_q   <= BASE_YEARS;
        mon_q  <= '0;
      end
      OP_HOUR: begin
        hour_q    <= hour_prod[25:21];
        day_min_q <= min_prod[29:19];
      end
      OP_MIN: begin
        min_q <= min_full[5:0];
        sec_q <= sec_full[5:0];
      end
      OP_YEAR: begin
        if (year_fwd) begin
          days_q <= days_q - $signed({7'd0, ylen_cur});
          ys_q   <= ys_q + 8'd1;
        end else if (year_back) begin
          days_q <= days_q + $signed({7'd0, ylen_prev});
          ys_q   <= ys_q - 8'd1;
        end else begin
          yday_q <= days_q[8:0];
        end
      end
      OP_MON: begin
        if (mon_adv) begin
          days_q <= days_q - $signed({11'd0, mlen});
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, packed from the lowest bit up
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q <= {2'b00, yday_q, weekday, ys_q, mon_q,
                   5'(days_q[4:0] + 5'd1), hour_q, min_q, sec_q};
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== design/epoch_to_calendar_convert_core.sv =====
`default_nettype none

// Channel  Direction  tdata fields (lowest bit up)
// s_axis   in         epoch_seconds[31:0], offset_seconds[49:32], zero fill to 56
// m_axis   out        second, minute, hour, day_of_month, month_index,
//                     years_since_1900, weekday, day_of_year, zero fill to 48
//
// One conversion runs through the load, division, day, hour and minute states,
// then the year and month stepping loops and the finish state; the day, hour
// and minute splits are reciprocal multiplies, and the loops step one year per
// cycle and one month per cycle.
// Reset clears the controller and the result valid flag; no clearing pass.
// A new input transfer is taken while a finished result still waits on m_axis;
// the next result waits in the controller until the output register is free.

module epoch_to_calendar_convert_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // epoch_seconds[31:0], offset_seconds[49:32], zeros[55:50]
  input  wire logic [e2c_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
  // month_index[25:22], years_since_1900[33:26], weekday[36:34],
  // day_of_year[45:37], zeros[47:46]
  output logic [e2c_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
  import e2c_pkg::*;

  cmd_t    cmd;
  status_t sts;

  e2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  e2c_datapath u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .epoch_seconds_i  ($signed(s_axis_tdata[31:0])),
    .offset_seconds_i ($signed(s_axis_tdata[49:32])),
    .sts_o            (sts),
    .result_o         (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import e2c_pkg::*;

  localparam longint DAY_SECS = 86400;
  localparam longint OFFSET_SAT = 86400;
  localparam int DIRECTED_N = 22;
  localparam int RANDOM_PER_PHASE = 295;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_PRINTS = 40;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Broken-down time as it sits in m_axis_tdata, second in the lowest bits
  typedef struct packed {
    logic [8:0] yday;
    logic [2:0] wday;
    logic [7:0] year;
    logic [3:0] mon;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  // One stimulus row; fixed marks a result typed in by hand
  typedef struct packed {
    logic [31:0] epoch;
    logic [17:0] offset;
    logic        fixed;
    cal_t        cal;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // epoch_seconds[31:0], offset_seconds[49:32], zeros[55:50]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // second, minute, hour, day_of_month, month_index, years_since_1900,
  // weekday, day_of_year, zeros[47:46]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  cal_t expected_dates [$];
  int   error_count = 0;
  int   result_count = 0;
  int   quiet_cycles = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;

  // Columns: epoch, offset, fixed, {yday, wday, year, mon, mday, hour, minute, second}
  row_t directed_rows [DIRECTED_N] = '{
    '{32'd0,          18'd0,      1'b1, '{9'd0,   3'd4, 8'd70,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'hFFFF_FFFF,  18'd0,      1'b1, '{9'd364, 3'd3, 8'd69,  4'd11, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'h7FFF_FFFF,  18'd0,      1'b1, '{9'd18,  3'd2, 8'd138, 4'd0,  5'd19, 5'd3,  6'd14, 6'd7}},
    '{32'h8000_0000,  18'd0,      1'b1, '{9'd346, 3'd5, 8'd1,   4'd11, 5'd13, 5'd20, 6'd45, 6'd52}},
    '{32'd0,          18'd86400,  1'b0, '0},
    '{32'd0,          18'd175744, 1'b0, '0},
    '{32'h7FFF_FFFF,  18'd86400,  1'b0, '0},
    '{32'h8000_0000,  18'd175744, 1'b0, '0},
    '{32'h7FFF_FFFF,  18'h1FFFF,  1'b0, '0},
    '{32'h8000_0000,  18'h20000,  1'b0, '0},
    '{32'd0,          18'd86401,  1'b0, '0},
    '{32'd0,          18'd175743, 1'b0, '0},
    '{32'd0,          18'h3FFFF,  1'b0, '0},
    '{32'd68169600,   18'd0,      1'b0, '0},
    '{32'd951782400,  18'd0,      1'b0, '0},
    '{32'd951868800,  18'd0,      1'b0, '0},
    '{32'd978220800,  18'd0,      1'b0, '0},
    '{32'd978307200,  18'd0,      1'b0, '0},
    '{32'd946684799,  18'd1,      1'b0, '0},
    '{32'd1709251199, 18'd3600,   1'b0, '0},
    '{32'h5555_5555,  18'h2AAAA,  1'b0, '0},
    '{32'hAAAA_AAAA,  18'h15555,  1'b0, '0}
  };

  epoch_to_calendar_convert_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint year_days(input longint yr);
    if (yr % 400 == 0) return 366;
    if (yr % 100 == 0) return 365;
    return (yr % 4 == 0) ? 366 : 365;
  endfunction

  // Seconds from 1970-01-01 to January first of the given year
  function automatic longint year_start_secs(input int yr);
    longint d;
    d = 0;
    for (int y = 1970; y < yr; y++) d += year_days(y);
    for (int y = yr; y < 1970; y++) d -= year_days(y);
    return d * DAY_SECS;
  endfunction

  // Split epoch plus clamped zone offset into calendar fields
  function automatic cal_t epoch_to_date(input logic [31:0] epoch, input logic [17:0] offset);
    longint ofs, total, day_num, tod, yr, wd;
    int     mon;
    int     mlen;
    cal_t   r;
    ofs = longint'($signed(offset));
    if (ofs > OFFSET_SAT) ofs = OFFSET_SAT;
    if (ofs < -OFFSET_SAT) ofs = -OFFSET_SAT;
    total = longint'($signed(epoch)) + ofs;
    day_num = total / DAY_SECS;
    tod = total % DAY_SECS;
    if (tod < 0) begin
      tod += DAY_SECS;
      day_num -= 1;
    end
    // 1970-01-01 was a Thursday
    wd = (4 + day_num) % 7;
    if (wd < 0) wd += 7;
    // Step whole years away from 1970
    yr = 1970;
    while (day_num >= year_days(yr)) begin
      day_num -= year_days(yr);
      yr++;
    end
    while (day_num < 0) begin
      yr--;
      day_num += year_days(yr);
    end
    r.yday = 9'(day_num);
    // Step through the months of that year
    mon = 0;
    mlen = MONTH_DAYS[0];
    while (mon < 11 && day_num >= mlen) begin
      day_num -= mlen;
      mon++;
      mlen = MONTH_DAYS[mon] + ((mon == 1 && year_days(yr) == 366) ? 1 : 0);
    end
    r.mday = 5'(day_num + 1);
    r.mon = 4'(mon);
    r.year = 8'(yr - 1900);
    r.wday = 3'(wd);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
  endtask

  // Compare one output transfer with the oldest pending date
  task automatic check_date(input cal_t got);
    cal_t want;
    result_count++;
    if (expected_dates.size() == 0) begin
      report_mismatch("result with none pending, data", got, 0);
    end else begin
      want = expected_dates.pop_front();
      if (got.second !== want.second) report_mismatch("second", got.second, want.second);
      if (got.minute !== want.minute) report_mismatch("minute", got.minute, want.minute);
      if (got.hour !== want.hour) report_mismatch("hour", got.hour, want.hour);
      if (got.mday !== want.mday) report_mismatch("day_of_month", got.mday, want.mday);
      if (got.mon !== want.mon) report_mismatch("month_index", got.mon, want.mon);
      if (got.year !== want.year) report_mismatch("years_since_1900", got.year, want.year);
      if (got.wday !== want.wday) report_mismatch("weekday", got.wday, want.wday);
      if (got.yday !== want.yday) report_mismatch("day_of_year", got.yday, want.yday);
    end
  endtask

  // Hold off at random, then present one conversion until it is taken
  task automatic send_conversion(input logic [31:0] epoch, input logic [17:0] offset,
                                 input cal_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, offset, epoch};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_dates.push_back(want);
  endtask

  // Random conversion: mostly full-range times, some near year edges and extremes
  task automatic send_random_conversion();
    logic [31:0] epoch;
    logic [17:0] offset;
    longint      e;
    int          pick;
    pick = $urandom_range(0, 9);
    epoch = $urandom;
    offset = 18'(int'($urandom_range(0, 172800)) - 86400);
    if (pick == 4 || pick == 5) begin
      offset = 18'($urandom_range(0, 262143));
    end else if (pick >= 6 && pick <= 8) begin
      e = year_start_secs($urandom_range(1902, 2038))
          + ($urandom_range(0, 1) ? 0 : 59 * DAY_SECS)
          + longint'($urandom_range(0, 172800)) - DAY_SECS;
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      epoch = e[31:0];
    end else if (pick == 9) begin
      epoch = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 200000)
                                   : 32'h8000_0000 + $urandom_range(0, 200000);
      offset = 18'($urandom_range(0, 262143));
    end
    send_conversion(epoch, offset, epoch_to_date(epoch, offset));
  endtask

  // Take results, stalling at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_date(m_axis_tdata[$bits(cal_t)-1:0]);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 69;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 69;
        end
        default: begin
          src_idle_pct = 19;
          sink_stall_pct = 19;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          send_conversion(directed_rows[i].epoch, directed_rows[i].offset,
                          directed_rows[i].fixed ? directed_rows[i].cal
                          : epoch_to_date(directed_rows[i].epoch, directed_rows[i].offset));
        end
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_conversion();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch for stray results
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== epoch_to_calendar_convert_core.f =====
design/e2c_pkg.sv
design/e2c_ctrl.sv
design/e2c_datapath.sv
design/epoch_to_calendar_convert_core.sv
tb/testbench.sv
